// ===== sv/flr_pkg.sv =====
`default_nettype none

package flr_pkg;

  localparam int DEF_WORDS   = 4;
  localparam int WORD_BITS   = 16;
  localparam int MAX_WORD_W  = 6;
  localparam int FULL_W      = 7;
  localparam int CNT_REG_W   = 7;
  localparam int CFG_DATA_W  = 7;
  localparam int CFG_INDEX_W = 1;
  localparam int ID_W        = 10;

  localparam logic [15:0] FULL_WORD = 16'hFFFF;
  localparam logic [CNT_REG_W-1:0] COUNT_RESET = 7'd64;

  localparam logic [1:0] OP_FAIL   = 2'd0;
  localparam logic [1:0] OP_CLEAR  = 2'd1;
  localparam logic [1:0] OP_CONFIG = 2'd2;
  localparam logic [1:0] OP_REPORT = 2'd3;

  localparam logic [CFG_INDEX_W-1:0] REG_DETECTOR_COUNT = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_REPORT_MODE    = 1'd1;

  typedef enum logic [3:0] {
    CMD_FAIL,
    CMD_CLR_ONE,
    CMD_EN_ONE,
    CMD_DIS_ONE,
    CMD_CLR_ALL,
    CMD_EN_ALL,
    CMD_DIS_ALL,
    CMD_REPORT,
    CMD_REJECT
  } kind_t;

  typedef struct packed {
    kind_t                 kind;
    logic [MAX_WORD_W-1:0] word;
    logic [3:0]            bit_pos;
    logic [FULL_W-1:0]     full;
    logic [3:0]            rem;
    logic                  mode;
  } cmd_t;

  typedef enum logic {
    BK_IDLE,
    BK_WALK
  } back_state_t;

endpackage

`default_nettype wire

// ===== sv/fault_latch_reporter_unit.sv =====
// Fault latch and report unit.
// Input channel (in_valid / in_stall) carries one event item: detector fail,
// clear, configure-enable or generate-report. Output channel (out_valid /
// out_stall) returns result items: one per fail, clear or configure event,
// and BITFIELD_WORDS per report event (one per packet word, last on the final).
// Configuration is a plain write port: cfg_index 0 sets detector_count,
// cfg_index 1 sets report_mode; write only while the unit is idle.
// A single-detector event is written into the command queue when it is
// accepted, then runs in the execute stage, which loads the output register.
// Throughput: single-detector events run at one item per cycle while the
// output is not stalled. A select-all clear or configure, and a report, walk
// the bitfield words one per cycle, also only while not stalled, holding the
// execute stage; the two-entry command queue takes items meanwhile until full.
// Reset clears all enable, latched, new-report and packet words at once, sets
// detector_count to 64 and report_mode to copy; the unit is ready next cycle.
// When the receiver stalls, the output register holds its item, the execute
// stage waits, and in_stall rises once the queue is full.
`default_nettype none

module fault_latch_reporter_unit #(
  parameter int BITFIELD_WORDS = flr_pkg::DEF_WORDS
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [flr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [flr_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [1:0]                      operation,
  input  wire logic [flr_pkg::ID_W-1:0]        fault_id,
  input  wire logic                            select_all,
  input  wire logic                            enable,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic                                 status,
  output logic [flr_pkg::MAX_WORD_W-1:0]       word_index,
  output logic [15:0]                          report_word,
  output logic                                 last
);
  import flr_pkg::*;

  cmd_t front_cmd;
  cmd_t head;
  logic q_full;
  logic head_valid;
  logic pop;
  logic push;

  // Accept an item whenever the queue has room.
  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  flr_front #(.BITFIELD_WORDS(BITFIELD_WORDS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .operation  (operation),
    .fault_id   (fault_id),
    .select_all (select_all),
    .enable     (enable),
    .cmd        (front_cmd)
  );

  flr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (front_cmd),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  flr_back #(.BITFIELD_WORDS(BITFIELD_WORDS)) u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (head_valid),
    .head        (head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .word_index  (word_index),
    .report_word (report_word),
    .last        (last)
  );

endmodule

`default_nettype wire

// ===== sv/flr_front.sv =====
`default_nettype none

module flr_front #(
  parameter int BITFIELD_WORDS = flr_pkg::DEF_WORDS
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [flr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [flr_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic [1:0]                      operation,
  input  wire logic [flr_pkg::ID_W-1:0]        fault_id,
  input  wire logic                            select_all,
  input  wire logic                            enable,
  output flr_pkg::cmd_t                        cmd
);
  import flr_pkg::*;

  localparam int CAP = BITFIELD_WORDS * WORD_BITS;
  localparam int CW  = ($clog2(CAP + 1) > ID_W) ? $clog2(CAP + 1) : ID_W;
  localparam logic [CW-1:0] CAP_C = CW'(CAP);

  logic [CNT_REG_W-1:0] detector_count;
  logic                 report_mode;
  logic [CW-1:0]        dc_x;
  logic [CW-1:0]        eff;
  logic                 id_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      detector_count <= COUNT_RESET;
      report_mode    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DETECTOR_COUNT: detector_count <= cfg_data[CNT_REG_W-1:0];
        REG_REPORT_MODE:    report_mode    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Cap the count so an id never reaches a word that does not exist.
  assign dc_x  = CW'(detector_count);
  assign eff   = (dc_x < CAP_C) ? dc_x : CAP_C;
  assign id_ok = CW'(fault_id) < eff;

  always_comb begin
    cmd.word    = fault_id[ID_W-1:4];
    cmd.bit_pos = fault_id[3:0];
    cmd.full    = FULL_W'(eff >> 4);
    cmd.rem     = eff[3:0];
    cmd.mode    = report_mode;
    case (operation)
      OP_FAIL:   cmd.kind = id_ok ? CMD_FAIL : CMD_REJECT;
      OP_CLEAR:  cmd.kind = select_all ? CMD_CLR_ALL : (id_ok ? CMD_CLR_ONE : CMD_REJECT);
      OP_CONFIG: begin
        if (select_all) cmd.kind = enable ? CMD_EN_ALL : CMD_DIS_ALL;
        else if (!id_ok) cmd.kind = CMD_REJECT;
        else cmd.kind = enable ? CMD_EN_ONE : CMD_DIS_ONE;
      end
      default:   cmd.kind = CMD_REPORT;
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/flr_queue.sv =====
`default_nettype none

module flr_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire flr_pkg::cmd_t push_cmd,
  output logic               full,
  input  wire logic          pop,
  output logic               head_valid,
  output flr_pkg::cmd_t      head
);
  import flr_pkg::*;

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign full       = fill == 2'd2;
  assign head_valid = fill != 2'd0;
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== sv/flr_back.sv =====
`default_nettype none

module flr_back #(
  parameter int BITFIELD_WORDS = flr_pkg::DEF_WORDS
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           head_valid,
  input  wire flr_pkg::cmd_t                  head,
  output logic                                pop,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic                                status,
  output logic [flr_pkg::MAX_WORD_W-1:0]      word_index,
  output logic [15:0]                         report_word,
  output logic                                last
);
  import flr_pkg::*;

  localparam int WI_W = (BITFIELD_WORDS > 1) ? $clog2(BITFIELD_WORDS) : 1;
  localparam logic [WI_W-1:0] LAST_W = WI_W'(BITFIELD_WORDS - 1);

  logic [15:0] enable_bits     [BITFIELD_WORDS];
  logic [15:0] latched_bits    [BITFIELD_WORDS];
  logic [15:0] new_report_bits [BITFIELD_WORDS];
  logic [15:0] report_packet   [BITFIELD_WORDS];

  back_state_t state, state_next;
  cmd_t        cmd;
  logic [WI_W-1:0] ptr, ptr_next;

  logic            out_ok;
  logic            take_walk;
  logic            ld;
  logic            o_status;
  logic [MAX_WORD_W-1:0] o_idx;
  logic [15:0]     o_word;
  logic            o_last;
  logic [WI_W-1:0] widx;
  logic            we;
  logic [15:0]     ena_w, lat_w, new_w, pkt_w;
  logic [15:0]     mask;
  logic [15:0]     rem_mask;

  assign out_ok = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
      ptr   <= '0;
    end else begin
      state <= state_next;
      ptr   <= ptr_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take_walk) cmd <= head;
  end

  always_comb begin
    state_next = state;
    ptr_next   = ptr;
    pop        = 1'b0;
    take_walk  = 1'b0;
    ld         = 1'b0;
    o_status   = 1'b0;
    o_idx      = '0;
    o_word     = '0;
    o_last     = 1'b1;
    we         = 1'b0;
    widx       = (state == BK_IDLE) ? WI_W'(head.word) : ptr;
    mask       = 16'(1) << ((state == BK_IDLE) ? head.bit_pos : cmd.bit_pos);
    rem_mask   = 16'((17'(1) << cmd.rem) - 17'(1));
    ena_w      = enable_bits[widx];
    lat_w      = latched_bits[widx];
    new_w      = new_report_bits[widx];
    pkt_w      = report_packet[widx];
    case (state)
      BK_IDLE: begin
        if (head_valid && out_ok) begin
          pop = 1'b1;
          case (head.kind)
            CMD_FAIL: begin
              ld = 1'b1;
              if ((ena_w & mask) != 16'd0) begin
                we    = 1'b1;
                lat_w = lat_w | mask;
                new_w = new_w | mask;
              end
            end
            CMD_CLR_ONE: begin
              ld    = 1'b1;
              we    = 1'b1;
              lat_w = lat_w & ~mask;
              new_w = new_w & ~mask;
              pkt_w = pkt_w & ~mask;
            end
            CMD_EN_ONE: begin
              ld    = 1'b1;
              we    = 1'b1;
              ena_w = ena_w | mask;
            end
            CMD_DIS_ONE: begin
              ld    = 1'b1;
              we    = 1'b1;
              ena_w = ena_w & ~mask;
            end
            CMD_REJECT: begin
              ld       = 1'b1;
              o_status = 1'b1;
            end
            default: begin
              take_walk  = 1'b1;
              ptr_next   = '0;
              state_next = BK_WALK;
            end
          endcase
        end
      end
      BK_WALK: begin
        if (out_ok) begin
          we = 1'b1;
          case (cmd.kind)
            CMD_CLR_ALL: begin
              lat_w = '0;
              new_w = '0;
              pkt_w = '0;
            end
            CMD_EN_ALL: begin
              if (FULL_W'(ptr) < cmd.full) ena_w = FULL_WORD;
              else if (FULL_W'(ptr) == cmd.full) ena_w = rem_mask;
            end
            CMD_DIS_ALL: ena_w = '0;
            default: begin
              // Report: merge or copy, then drop the new-report word.
              pkt_w = cmd.mode ? (pkt_w | new_w) : new_w;
              new_w = '0;
              ld     = 1'b1;
              o_idx  = MAX_WORD_W'(ptr);
              o_word = pkt_w;
              o_last = ptr == LAST_W;
            end
          endcase
          if (ptr == LAST_W) begin
            ld         = 1'b1;
            state_next = BK_IDLE;
          end else begin
            ptr_next = ptr + WI_W'(1);
          end
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < BITFIELD_WORDS; i++) begin
        enable_bits[i]     <= '0;
        latched_bits[i]    <= '0;
        new_report_bits[i] <= '0;
        report_packet[i]   <= '0;
      end
    end else if (we) begin
      enable_bits[widx]     <= ena_w;
      latched_bits[widx]    <= lat_w;
      new_report_bits[widx] <= new_w;
      report_packet[widx]   <= pkt_w;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ld) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      status      <= o_status;
      word_index  <= o_idx;
      report_word <= o_word;
      last        <= o_last;
    end
  end

endmodule

`default_nettype wire

// ===== sv/flr_checker.sv =====
`default_nettype none

module flr_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic        status,
  input wire logic [5:0]  word_index,
  input wire logic [15:0] report_word,
  input wire logic        last
);

  // Hold a stalled result.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(report_word) && $stable(word_index))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  // Only reports give more than one result, and they never reject.
  a_multi_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> !status)
    else $error("non-final result with invalid status");

  a_reject_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> last && word_index == 6'd0 && report_word == 16'd0)
    else $error("rejected item with report payload");

endmodule

bind fault_latch_reporter_unit flr_checker u_flr_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .status      (status),
  .word_index  (word_index),
  .report_word (report_word),
  .last        (last)
);

`default_nettype wire
